>>> rtl/csvt_pkg.sv
// Shared types, constants and per-byte parse functions of the CSV tokenizer.
package csvt_pkg;

  localparam int MAX_FIELDS = 256;
  localparam int FT_W       = $clog2(MAX_FIELDS + 2);
  localparam int EXP_W      = 9;
  localparam int CMP_W      = (FT_W > EXP_W) ? FT_W : EXP_W;
  localparam int EV_MAX     = 4;
  localparam int EV_AW      = $clog2(EV_MAX);
  localparam int N_W        = $clog2(EV_MAX + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    EV_CONTENT,
    EV_FIELD,
    EV_RECORD,
    EV_ERROR
  } ev_kind_t;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN,
    MODE_QCR
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } tok_in_t;

  typedef struct packed {
    ev_kind_t   event_kind;
    logic [7:0] content_byte;
    logic [7:0] field_number;
    logic       field_was_quoted;
    logic       field_is_empty;
    logic       count_mismatch;
    logic       dos_line_end;
    logic       last_of_item;
  } tok_out_t;

  typedef struct packed {
    mode_t           mode;
    logic            afs;
    logic            pcr;
    logic [7:0]      cf;
    logic            fhc;
    logic            cq;
    logic            rs;
    logic [FT_W-1:0] ft;
  } st_t;

  typedef struct packed {
    st_t                       s;
    tok_out_t [EV_MAX-1:0]     ev;
    logic [N_W-1:0]            n;
    logic                      err;
  } acc_t;

  typedef struct packed {
    logic [N_W-1:0]        n;
    tok_out_t [EV_MAX-1:0] ev;
  } tok_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam st_t ST_RESET = '{
    mode: MODE_PLAIN, afs: 1'b1, pcr: 1'b0, cf: 8'd0,
    fhc: 1'b0, cq: 1'b0, rs: 1'b0, ft: '0
  };

  function automatic tok_out_t mk_ev(ev_kind_t k, logic [7:0] b, logic [7:0] fn,
                                     logic q, logic e, logic mm, logic dos);
    tok_out_t r;
    r.event_kind       = k;
    r.content_byte     = b;
    r.field_number     = fn;
    r.field_was_quoted = q;
    r.field_is_empty   = e;
    r.count_mismatch   = mm;
    r.dos_line_end     = dos;
    r.last_of_item     = 1'b0;
    return r;
  endfunction

  function automatic acc_t push_ev(acc_t a, tok_out_t e);
    acc_t r;
    r = a;
    if (a.n < N_W'(EV_MAX)) begin
      r.ev[a.n[EV_AW-1:0]] = e;
      r.n = a.n + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t add_content(acc_t a, logic [7:0] b);
    acc_t r;
    r = push_ev(a, mk_ev(EV_CONTENT, b, a.s.cf, 1'b0, 1'b0, 1'b0, 1'b0));
    r.s.fhc = 1'b1;
    r.s.afs = 1'b0;
    r.s.rs  = 1'b1;
    return r;
  endfunction

  function automatic acc_t end_field(acc_t a);
    acc_t r;
    r = push_ev(a, mk_ev(EV_FIELD, 8'd0, a.s.cf, a.s.cq, !a.s.fhc, 1'b0, 1'b0));
    if (a.s.ft <= FT_W'(MAX_FIELDS)) begin
      r.s.ft = a.s.ft + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t next_field(acc_t a);
    acc_t r;
    r = end_field(a);
    if (r.s.cf != 8'hFF) begin
      r.s.cf = r.s.cf + 8'd1;
    end
    r.s.afs  = 1'b1;
    r.s.fhc  = 1'b0;
    r.s.cq   = 1'b0;
    r.s.rs   = 1'b1;
    r.s.mode = MODE_PLAIN;
    return r;
  endfunction

  function automatic acc_t end_line(acc_t a, logic dos, logic [EXP_W-1:0] exp_fields);
    acc_t r;
    logic mm;
    r = a;
    if (a.s.rs) begin
      r  = end_field(a);
      mm = (exp_fields != '0) &&
           ((r.s.ft > FT_W'(MAX_FIELDS)) || (CMP_W'(r.s.ft) != CMP_W'(exp_fields)));
      r  = push_ev(r, mk_ev(EV_RECORD, 8'd0, r.s.cf, 1'b0, 1'b0, mm, dos));
    end
    r.s = ST_RESET;
    return r;
  endfunction

  function automatic acc_t raise_error(acc_t a);
    acc_t r;
    r = push_ev(a, mk_ev(EV_ERROR, 8'd0, a.s.cf, 1'b0, 1'b0, 1'b0, 1'b0));
    r.err = 1'b1;
    return r;
  endfunction

  function automatic acc_t tok_step(st_t s, logic [7:0] b, logic eoi,
                                    logic [EXP_W-1:0] exp_fields);
    acc_t a;
    logic endl;
    logic dosl;
    logic fin_dos;
    a.s   = s;
    a.ev  = '0;
    a.n   = '0;
    a.err = 1'b0;
    endl  = 1'b0;
    dosl  = 1'b0;
    case (s.mode)
      MODE_PLAIN: begin
        if (s.pcr) begin
          a.s.pcr = 1'b0;
          if (b == CH_LF) begin
            endl = 1'b1;
            dosl = 1'b1;
          end else begin
            a = add_content(a, CH_CR);
          end
        end
        if (!endl) begin
          case (b)
            CH_COMMA: a = next_field(a);
            CH_QUOTE: begin
              if (a.s.afs) begin
                a.s.mode = MODE_QUOTED;
                a.s.cq   = 1'b1;
                a.s.afs  = 1'b0;
                a.s.rs   = 1'b1;
              end else begin
                a = raise_error(a);
              end
            end
            CH_LF:   endl = 1'b1;
            CH_CR:   a.s.pcr = 1'b1;
            default: a = add_content(a, b);
          endcase
        end
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          a.s.mode = MODE_QSEEN;
        end else begin
          a = add_content(a, b);
        end
      end
      MODE_QSEEN: begin
        case (b)
          CH_QUOTE: begin
            a.s.mode = MODE_QUOTED;
            a = add_content(a, CH_QUOTE);
          end
          CH_COMMA: a = next_field(a);
          CH_LF:    endl = 1'b1;
          CH_CR:    a.s.mode = MODE_QCR;
          default:  a = raise_error(a);
        endcase
      end
      default: begin
        if (b == CH_LF) begin
          endl = 1'b1;
          dosl = 1'b1;
        end else begin
          a = raise_error(a);
        end
      end
    endcase
    if (endl) begin
      a = end_line(a, dosl, exp_fields);
    end
    if (!a.err && eoi) begin
      if (a.s.mode == MODE_QUOTED) begin
        a = raise_error(a);
      end else begin
        fin_dos = (a.s.mode == MODE_QCR) || ((a.s.mode == MODE_PLAIN) && a.s.pcr);
        a = end_line(a, fin_dos, exp_fields);
      end
    end
    return a;
  endfunction

endpackage

>>> rtl/csvt_front.sv
// Front end: accepts bytes, runs the parse state and pushes each byte's words as a bundle.
module csvt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  csvt_pkg::tok_in_t              in_data,
  input  logic [csvt_pkg::EXP_W-1:0]     exp_fields,
  input  csvt_pkg::q_stat_t              q_stat,
  output logic                           push,
  output csvt_pkg::tok_bundle_t          push_data
);

  csvt_pkg::st_t  st_r, st_nxt;
  logic           halted_r, halted_nxt;
  csvt_pkg::acc_t acc;
  logic           accept;

  always_comb begin
    in_stall   = q_stat.full;
    accept     = in_valid && !q_stat.full;
    acc        = csvt_pkg::tok_step(st_r, in_data.text_byte, in_data.end_of_input, exp_fields);
    st_nxt     = st_r;
    halted_nxt = halted_r;
    if (accept && !halted_r) begin
      st_nxt     = acc.s;
      halted_nxt = acc.err;
    end
    push         = accept && !halted_r && (acc.n != '0);
    push_data.n  = acc.n;
    push_data.ev = acc.ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= csvt_pkg::ST_RESET;
      halted_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> rtl/csvt_queue.sv
// Short bundle queue between the parse front end and the word emitter.
module csvt_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csvt_pkg::tok_bundle_t push_data,
  input  logic                  pop,
  output csvt_pkg::tok_bundle_t head,
  output csvt_pkg::q_stat_t     stat
);

  csvt_pkg::tok_bundle_t         mem [csvt_pkg::Q_DEPTH];
  logic [csvt_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [csvt_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [csvt_pkg::Q_AW:0]       cnt_r, cnt_nxt;

  always_comb begin
    stat.full  = (cnt_r == (csvt_pkg::Q_AW + 1)'(csvt_pkg::Q_DEPTH));
    stat.empty = (cnt_r == '0);
    head       = mem[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (csvt_pkg::Q_AW + 1)'(csvt_pkg::Q_DEPTH))
    else $error("queue count out of range");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

>>> rtl/csvt_back.sv
// Back end: unpacks bundles, emits one word per cycle via out_data_r unless stalled.
module csvt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csvt_pkg::tok_bundle_t head,
  input  csvt_pkg::q_stat_t     q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output csvt_pkg::tok_out_t    out_data
);

  logic                        cur_v_r, cur_v_nxt;
  csvt_pkg::tok_bundle_t       cur_r, cur_nxt;
  logic [csvt_pkg::EV_AW-1:0]  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  csvt_pkg::tok_out_t          out_data_r, out_data_nxt;
  logic                        out_free;
  logic                        adv;
  logic                        last;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    adv           = cur_v_r && out_free;
    last          = ({1'b0, idx_r} + 1'b1) == cur_r.n;
    pop           = (!cur_v_r || (adv && last)) && !q_stat.empty;
    out_valid_nxt = out_free ? adv : out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_data_nxt              = cur_r.ev[idx_r];
      out_data_nxt.last_of_item = last;
    end
    cur_nxt   = pop ? head : cur_r;
    cur_v_nxt = pop ? 1'b1 : ((adv && last) ? 1'b0 : cur_v_r);
    idx_nxt   = pop ? '0 : (adv ? idx_r + 1'b1 : idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r     <= cur_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/csv_byte_stream_tokenizer_unit.sv
// CSV byte tokenizer top level: config register, front end, bundle queue and word emitter.
// Takes one byte per cycle whenever the four-entry bundle queue has room; each byte yields zero
// to four words (content, end of field, end of record, format error), and the output register
// emits one word per cycle while out_stall is low, so the sustained rate is one byte per cycle
// as long as bytes average at most one word, set by that single output register. A word passes
// the queue, cur_r and out_data_r. After a format error further bytes are taken and dropped
// until reset. expected_fields is written through the cfg port, which is always ready.
module csv_byte_stream_tokenizer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  csvt_pkg::tok_in_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output csvt_pkg::tok_out_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csvt_pkg::EXP_W-1:0]     cfg_data
);

  logic [csvt_pkg::EXP_W-1:0] exp_fields_r, exp_fields_nxt;
  csvt_pkg::q_stat_t          q_stat;
  csvt_pkg::tok_bundle_t      push_data;
  csvt_pkg::tok_bundle_t      head;
  logic                       push;
  logic                       pop;

  always_comb begin
    cfg_ready      = 1'b1;
    exp_fields_nxt = (cfg_valid && cfg_ready) ? cfg_data : exp_fields_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_fields_r <= '0;
    end else begin
      exp_fields_r <= exp_fields_nxt;
    end
  end

  csvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .exp_fields (exp_fields_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  csvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  csvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
